// ===== rtl/fmmd_pkg.sv =====
// Shared constants, command codes and types for the marker message deframer.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package fmmd_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int WORD_W      = 32;
    localparam int POS_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Marker patterns: +infinity opens a message, -infinity closes it
    localparam logic [WORD_W-1:0] START_MARK = 32'h7F80_0000;
    localparam logic [WORD_W-1:0] END_MARK   = 32'hFF80_0000;

    // Command kinds passed from front to back
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] data;
    } cmd_t;

    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fmmd_front.sv =====
// Front end: accepts words, tracks message framing, issues commands.
// Depends on fmmd_pkg; feeds fmmd_queue.
`default_nettype none

module fmmd_front
    import fmmd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] word_in,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              queue_full,
    output logic                   busy,
    output logic                   push,
    output cmd_t                   push_cmd
);

    logic receiving_reg;
    logic receiving_next;
    logic reverse_reg;
    logic accept;

    assign busy   = queue_full;
    assign accept = start && !busy;

    // Classify the word against the markers as received
    always_comb
    begin
        receiving_next = receiving_reg;
        push           = 1'b0;
        push_cmd.kind  = CMD_DATA;
        push_cmd.data  = reverse_reg ? swap_bytes(word_in) : word_in;
        if (accept)
        begin
            if (!receiving_reg)
            begin
                if (word_in == START_MARK)
                begin
                    receiving_next = 1'b1;
                    push           = 1'b1;
                    push_cmd.kind  = CMD_START;
                end
            end
            else if (word_in == END_MARK)
            begin
                receiving_next = 1'b0;
                push           = 1'b1;
                push_cmd.kind  = CMD_END;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    // Hold framing state and the byte order setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            reverse_reg   <= 1'b0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            if (cfg_we)
            begin
                reverse_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fmmd_queue.sv =====
// Short command queue between front and back ends.
// Depends on fmmd_pkg for cmd_t and the queue depth.
`default_nettype none

module fmmd_queue
    import fmmd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head_cmd,
    output logic      full,
    output logic      empty
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fmmd_back.sv =====
// Back end: message store, fill index and playout sequencer.
// Depends on fmmd_pkg; drains fmmd_queue and drives the result ports.
`default_nettype none

module fmmd_back
    import fmmd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              head_cmd,
    input  wire logic              queue_empty,
    output logic                   pop,
    output logic                   result_valid,
    output logic [WORD_W-1:0]      word_out,
    output logic [POS_W-1:0]       word_position,
    output logic [POS_W-1:0]       message_length,
    output logic                   empty_message,
    output logic                   last_word
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PLAY = 1'b1;

    logic [WORD_W-1:0] store_mem [CAPACITY];
    logic [WORD_W-1:0] rd_data_reg;

    logic              state_reg;
    logic              state_next;
    logic [IDX_W-1:0]  fill_reg;
    logic [IDX_W-1:0]  fill_next;
    logic [IDX_W-1:0]  len_reg;
    logic [IDX_W-1:0]  len_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;
    logic [IDX_W-1:0]  rd_idx_inc;

    logic              wr_en;
    logic              rd_en;
    logic              play_last;

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_pos_reg, out_pos_next;
    logic [IDX_W-1:0]  out_len_reg, out_len_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_last_reg, out_last_next;

    assign rd_idx_inc = rd_idx_reg + IDX_W'(1);
    assign play_last  = (rd_idx_inc == len_reg);
    assign pop        = (state_reg == ST_IDLE) && !queue_empty;
    assign wr_en      = pop && (head_cmd.kind == CMD_DATA);
    assign rd_en      = (state_reg == ST_PLAY);

    // Carry out one command or one playout step per cycle
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = 1'b0;
        out_pos_next   = rd_idx_reg;
        out_len_next   = len_reg;
        out_empty_next = 1'b0;
        out_last_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head_cmd.kind)
                        CMD_START:
                        begin
                            fill_next = '0;
                        end
                        CMD_DATA:
                        begin
                            if (fill_reg != IDX_W'(CAPACITY - 1))
                            begin
                                fill_next = fill_reg + IDX_W'(1);
                            end
                        end
                        CMD_END:
                        begin
                            if (fill_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_pos_next   = '0;
                                out_len_next   = '0;
                                out_empty_next = 1'b1;
                                out_last_next  = 1'b1;
                            end
                            else
                            begin
                                len_next    = fill_reg;
                                rd_idx_next = '0;
                                state_next  = ST_PLAY;
                            end
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end
            ST_PLAY:
            begin
                out_valid_next = 1'b1;
                out_last_next  = play_last;
                if (play_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_idx_next = rd_idx_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Write data words and read the store for playout
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[fill_reg] <= head_cmd.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_idx_reg];
        end
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result fields, aligned with the registered store read
    always_ff @(posedge clk)
    begin
        out_pos_reg   <= out_pos_next;
        out_len_reg   <= out_len_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign result_valid   = out_valid_reg;
    assign word_out       = out_empty_reg ? '0 : rd_data_reg;
    assign word_position  = POS_W'(out_pos_reg);
    assign message_length = POS_W'(out_len_reg);
    assign empty_message  = out_empty_reg;
    assign last_word      = out_last_reg;

    // Checks on playout sequencing
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_empty_reg |-> out_last_reg)
        else $error("empty message result not marked last");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_empty_reg |-> out_pos_reg < out_len_reg)
        else $error("word position beyond message length");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg && !out_empty_reg
        |-> out_pos_reg + IDX_W'(1) == out_len_reg)
        else $error("last mark not on final word");

    a_no_pop_in_play: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PLAY |-> !pop && !wr_en)
        else $error("command taken during playout");

endmodule

`default_nettype wire

// ===== rtl/float_marker_message_deframer.sv =====
// Top level of the float marker message deframer.
// Depends on fmmd_pkg, fmmd_front, fmmd_queue and fmmd_back.
//
// Words are taken on start while busy is low; the front end accepts one word
// per cycle and queues a command for the start marker, the end marker and
// each data word, so busy rises only when the two-entry command queue is full.
// The back end carries out one queued command per cycle while idle; an end
// marker for a non-empty message starts playout, during which no command is
// taken (one store read per cycle on its single read port), while an empty
// message gives a single result. Each result appears in the cycle after its store
// read, for exactly one cycle on result_valid, and cannot be held off. The store
// has no clearing pass after reset; playout reads only words written in the
// current message.
`default_nettype none

module float_marker_message_deframer
    import fmmd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [WORD_W-1:0] word_in,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    output logic                   result_valid,
    output logic [WORD_W-1:0]      word_out,
    output logic [POS_W-1:0]       word_position,
    output logic [POS_W-1:0]       message_length,
    output logic                   empty_message,
    output logic                   last_word
);

    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head_cmd;
    logic queue_full;
    logic queue_empty;

    fmmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .word_in    (word_in),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    fmmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    fmmd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_cmd       (head_cmd),
        .queue_empty    (queue_empty),
        .pop            (pop),
        .result_valid   (result_valid),
        .word_out       (word_out),
        .word_position  (word_position),
        .message_length (message_length),
        .empty_message  (empty_message),
        .last_word      (last_word)
    );

endmodule

`default_nettype wire
